@@ rtl/core/nfc_pkg.sv @@
// ----------------------------------------------------------------------------
// nfc_pkg
// Format codes, status codes and widths shared by the element converter.
// ----------------------------------------------------------------------------
package nfc_pkg;

	localparam int unsigned FmtW = 3;
	localparam int unsigned StW  = 2;

	localparam logic [FmtW-1:0] FMT_F32  = 3'd0;
	localparam logic [FmtW-1:0] FMT_F64  = 3'd1;
	localparam logic [FmtW-1:0] FMT_I32  = 3'd2;
	localparam logic [FmtW-1:0] FMT_I64  = 3'd3;
	localparam logic [FmtW-1:0] FMT_BOOL = 3'd4;

	localparam logic [StW-1:0] ST_OK  = 2'd0;
	localparam logic [StW-1:0] ST_SAT = 2'd1;
	localparam logic [StW-1:0] ST_NAN = 2'd2;

	localparam logic CFG_SRC = 1'b0;
	localparam logic CFG_TGT = 1'b1;

endpackage

@@ rtl/core/numeric_format_converter.sv @@
// ----------------------------------------------------------------------------
// numeric_format_converter
// Converts tensor elements between binary32, binary64, int32, int64 and
// boolean, one element per item.
// ----------------------------------------------------------------------------
// Items enter on source_bits/last_in under in_valid/in_stall and leave on
// result_bits/status/last_out under out_valid/out_stall. Formats are set
// through the write port (index 0 source, 1 target); the user must set them
// only while the block is idle, as the block does not enforce it. An accepted
// item is captured in an input register, converted by combinational logic and
// held in the result register. One item is taken every cycle when the receiver
// does not stall. When it stalls, the result register holds and the input
// register keeps at most one more item, after which in_stall rises. Reset
// empties both registers and sets the formats to binary32 in and binary64 out.
// ----------------------------------------------------------------------------
module numeric_format_converter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [nfc_pkg::FmtW-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [63:0]              source_bits,
	input  logic                     last_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [63:0]              result_bits,
	output logic [nfc_pkg::StW-1:0]  status,
	output logic                     last_out
);
	import nfc_pkg::*;

	logic [FmtW-1:0] src_fmt_q;
	logic [FmtW-1:0] tgt_fmt_q;
	logic            vld_s1;
	logic [63:0]     bits_s1;
	logic            last_s1;
	logic            vld_s2;
	logic [63:0]     r_c;
	logic [StW-1:0]  st_c;
	logic            adv_s2;
	logic            adv_s1;

	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_F32;
			tgt_fmt_q <= FMT_F64;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SRC) begin
					src_fmt_q <= cfg_data;
				end else begin
					tgt_fmt_q <= cfg_data;
				end
			end
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			bits_s1 <= source_bits;
			last_s1 <= last_in;
		end
		if (adv_s2 && vld_s1) begin
			result_bits <= r_c;
			status      <= st_c;
			last_out    <= last_s1;
		end
	end

	nfc_convert u_conv (
		.src_fmt(src_fmt_q),
		.tgt_fmt(tgt_fmt_q),
		.x_in   (bits_s1),
		.r_out  (r_c),
		.st_out (st_c)
	);

	assign out_valid = vld_s2;

endmodule

@@ rtl/core/nfc_convert.sv @@
// ----------------------------------------------------------------------------
// nfc_convert
// Combinational conversion of one element between the supported formats.
// ----------------------------------------------------------------------------
module nfc_convert (
	input  logic [nfc_pkg::FmtW-1:0] src_fmt,
	input  logic [nfc_pkg::FmtW-1:0] tgt_fmt,
	input  logic [63:0]              x_in,
	output logic [63:0]              r_out,
	output logic [nfc_pkg::StW-1:0]  st_out
);
	import nfc_pkg::*;

	function automatic logic [6:0] top_bit(input logic [63:0] v);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				p = 7'(i);
			end
		end
		return p;
	endfunction

	// Shift right with round to nearest even; sh of 64 or more gives zero.
	function automatic logic [63:0] rnd_shift(input logic [63:0] v, input logic [10:0] sh);
		logic [63:0] keep;
		logic [63:0] rem;
		logic [63:0] half;
		if (sh == 11'd0) begin
			return v;
		end
		if (sh >= 11'd64) begin
			return '0;
		end
		keep = v >> sh;
		rem  = v & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 11'd1);
		if (rem > half || (rem == half && keep[0])) begin
			keep = keep + 64'd1;
		end
		return keep;
	endfunction

	function automatic logic [65:0] f2i(input logic [63:0] b, input logic dbl,
			input logic w64);
		logic        s;
		logic [10:0] e;
		logic [10:0] emax;
		logic [10:0] bias;
		logic [51:0] f;
		logic [5:0]  mb;
		logic [10:0] ex;
		logic [10:0] wm1;
		logic [63:0] maxv;
		logic [63:0] minv;
		logic [63:0] mag;
		logic [63:0] res;
		if (dbl) begin
			s = b[63]; e = b[62:52]; f = b[51:0]; emax = 11'h7ff; bias = 11'd1023;
			mb = 6'd52;
		end else begin
			s = b[31]; e = {3'd0, b[30:23]}; f = {29'd0, b[22:0]}; emax = 11'hff;
			bias = 11'd127; mb = 6'd23;
		end
		wm1  = w64 ? 11'd63 : 11'd31;
		maxv = w64 ? 64'h7fff_ffff_ffff_ffff : 64'h0000_0000_7fff_ffff;
		minv = w64 ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		if (e == emax) begin
			if (f != '0) begin
				return {ST_NAN, 64'd0};
			end
			return {ST_SAT, s ? minv : maxv};
		end
		if (e < bias) begin
			return {ST_OK, 64'd0};
		end
		ex = e - bias;
		if (ex >= wm1) begin
			if (s && ex == wm1 && f == '0) begin
				return {ST_OK, minv};
			end
			return {ST_SAT, s ? minv : maxv};
		end
		mag = (64'd1 << mb) | {12'd0, f};
		if (ex >= {5'd0, mb}) begin
			mag = mag << (ex - {5'd0, mb});
		end else begin
			mag = mag >> ({5'd0, mb} - ex);
		end
		res = s ? (64'd0 - mag) : mag;
		if (!w64) begin
			res[63:32] = '0;
		end
		return {ST_OK, res};
	endfunction

	function automatic logic [63:0] i2f(input logic [63:0] mag, input logic s,
			input logic dbl);
		logic [6:0]  p;
		logic [63:0] keep;
		logic [63:0] ebits;
		if (mag == '0) begin
			return '0;
		end
		p = top_bit(mag);
		if (dbl) begin
			if (p <= 7'd52) begin
				keep = mag << (7'd52 - p);
			end else begin
				keep = rnd_shift(mag, {4'd0, p - 7'd52});
			end
			ebits = (64'(p) + 64'd1022) << 52;
			return (ebits + keep) | {s, 63'd0};
		end
		if (p <= 7'd23) begin
			keep = mag << (7'd23 - p);
		end else begin
			keep = rnd_shift(mag, {4'd0, p - 7'd23});
		end
		ebits = (64'(p) + 64'd126) << 23;
		return (ebits + keep) | {32'd0, s, 31'd0};
	endfunction

	function automatic logic [63:0] widen(input logic [31:0] v);
		logic [63:0] hi;
		logic [7:0]  e;
		logic [22:0] f;
		logic [6:0]  p;
		logic [63:0] fs;
		hi = {v[31], 63'd0};
		e  = v[30:23];
		f  = v[22:0];
		if (e == 8'hff) begin
			if (f != '0) begin
				return hi | {1'b0, 11'h7ff, f, 29'd0} | {12'd0, 1'b1, 51'd0};
			end
			return hi | {1'b0, 11'h7ff, 52'd0};
		end
		if (e == 8'd0) begin
			if (f == '0) begin
				return hi;
			end
			p  = top_bit({41'd0, f});
			fs = ({41'd0, f} << (7'd52 - p)) & 64'h000f_ffff_ffff_ffff;
			return hi | ((64'(p) + 64'd874) << 52) | fs;
		end
		return hi | ((64'(e) + 64'd896) << 52) | {12'd0, f, 29'd0};
	endfunction

	function automatic logic [31:0] narrow(input logic [63:0] v);
		logic [31:0] hi;
		logic [10:0] e;
		logic [51:0] f;
		logic [63:0] sig;
		logic [63:0] keep;
		logic [63:0] bits;
		hi = {v[63], 31'd0};
		e  = v[62:52];
		f  = v[51:0];
		if (e == 11'h7ff) begin
			if (f != '0) begin
				return hi | 32'h7fc0_0000 | {9'd0, f[51:29]};
			end
			return hi | 32'h7f80_0000;
		end
		if (e == 11'd0) begin
			return hi;
		end
		if (e > 11'd1150) begin
			return hi | 32'h7f80_0000;
		end
		sig = {11'd0, 1'b1, f};
		if (e >= 11'd897) begin
			keep = rnd_shift(sig, 11'd29);
			bits = (64'(e - 11'd897) << 23) + keep;
			if (bits >= 64'h7f80_0000) begin
				bits = 64'h7f80_0000;
			end
			return hi | bits[31:0];
		end
		keep = rnd_shift(sig, 11'd926 - e);
		return hi | keep[31:0];
	endfunction

	logic [63:0] x;
	logic [63:0] r;
	logic [63:0] mag;
	logic        sgn;
	logic [65:0] fi;
	logic [StW-1:0] st;

	always_comb begin
		x   = x_in;
		r   = '0;
		st  = ST_OK;
		sgn = 1'b0;
		mag = '0;
		fi  = '0;
		case (src_fmt)
			FMT_F32, FMT_I32: x[63:32] = '0;
			FMT_BOOL:         x[63:8]  = '0;
			default:          x = x_in;
		endcase
		if (src_fmt <= FMT_BOOL && tgt_fmt <= FMT_BOOL) begin
			if (src_fmt == tgt_fmt) begin
				r = x;
			end else if (tgt_fmt == FMT_BOOL) begin
				if (src_fmt == FMT_F32) begin
					r = {63'd0, x[30:0] != '0};
				end else if (src_fmt == FMT_F64) begin
					r = {63'd0, x[62:0] != '0};
				end else begin
					r = {63'd0, x != '0};
				end
			end else if (src_fmt == FMT_BOOL) begin
				if (x != '0) begin
					case (tgt_fmt)
						FMT_F32: r = 64'h3f80_0000;
						FMT_F64: r = 64'h3ff0_0000_0000_0000;
						default: r = 64'd1;
					endcase
				end
			end else if (src_fmt == FMT_F32) begin
				if (tgt_fmt == FMT_F64) begin
					r = widen(x[31:0]);
				end else begin
					fi = f2i(x, 1'b0, tgt_fmt == FMT_I64);
					r  = fi[63:0];
					st = fi[65:64];
				end
			end else if (src_fmt == FMT_F64) begin
				if (tgt_fmt == FMT_F32) begin
					r = {32'd0, narrow(x)};
				end else begin
					fi = f2i(x, 1'b1, tgt_fmt == FMT_I64);
					r  = fi[63:0];
					st = fi[65:64];
				end
			end else begin
				if (src_fmt == FMT_I32) begin
					sgn = x[31];
					mag = sgn ? {32'd0, 32'd0 - x[31:0]} : x;
				end else begin
					sgn = x[63];
					mag = sgn ? (64'd0 - x) : x;
				end
				case (tgt_fmt)
					FMT_F32: r = i2f(mag, sgn, 1'b0);
					FMT_F64: r = i2f(mag, sgn, 1'b1);
					FMT_I64: r = sgn ? (x | 64'hffff_ffff_0000_0000) : x;
					default: r = {32'd0, x[31:0]};
				endcase
			end
			case (tgt_fmt)
				FMT_F32, FMT_I32: r[63:32] = '0;
				FMT_BOOL:         r[63:8]  = '0;
				default:          r = r;
			endcase
		end
	end

	assign r_out  = r;
	assign st_out = st;

endmodule
